>>> design/pdv_pkg.sv
// Package: constants, types and state codes for the pair difference variance block.
package pdv_pkg;
  localparam int MaxRows  = 256;
  localparam int MaxCols  = 64;
  localparam int FracBits = 16;
  localparam int RowW     = $clog2(MaxRows);
  localparam int ColW     = $clog2(MaxCols);
  localparam int AddrW    = RowW + ColW;
  localparam int RcntW    = 9;
  localparam int CcntW    = 7;
  localparam int DiffW    = 33;
  localparam int SumW     = DiffW + RowW;
  localparam int DevW     = DiffW + 1;
  localparam int SqW      = 2 * DevW;
  localparam int AccW     = SqW + RowW;
  localparam int DivW     = RowW + 1 + FracBits;

  localparam logic       OpLoad  = 1'b0;
  localparam logic       OpQuery = 1'b1;
  localparam logic       RegRows = 1'b0;
  localparam logic       RegCols = 1'b1;

  typedef enum logic [7:0] {
    StIdle = 8'b0000_0001,
    StRdA  = 8'b0000_0010,
    StRdB  = 8'b0000_0100,
    StAcc  = 8'b0000_1000,
    StMul  = 8'b0001_0000,
    StSq   = 8'b0010_0000,
    StDiv  = 8'b0100_0000,
    StOut  = 8'b1000_0000
  } state_e;
endpackage

>>> design/pdv_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module pdv_divider import pdv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AccW-1:0]   dividend_i,
  input  logic [DivW-1:0]   divisor_i,
  output logic              done_o,
  output logic [AccW-1:0]   quot_o
);
  localparam int CntW = $clog2(AccW + 1);
  logic [AccW-1:0] quot_q, quot_d;
  logic [DivW:0]   rem_q, rem_d;
  logic [DivW-1:0] dsr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;
  logic [DivW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q[DivW-1:0], quot_q[AccW-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(AccW);
      run_d  = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        quot_d = {quot_q[AccW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[AccW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) dsr_q <= divisor_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

>>> design/pairwise_difference_variance.sv
// Top level: column store, row-walk sequencer and shared divider.
// A load writes the store and leaves busy low. A query of distinct valid columns
// keeps busy high through a mean pass (two reads and an add per row), a square pass
// (two reads, a magnitude, a multiply and an accumulate per row) and a division
// after each pass, paced by the single store read port, one squarer and the
// bit-serial divider. Other queries skip the walk. Reset sets row_count 256, col_count 64.
module pairwise_difference_variance import pdv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation_i,
  input  logic [RowW-1:0]       row_index_i,
  input  logic [ColW-1:0]       col_index_i,
  input  logic [ColW-1:0]       other_col_i,
  input  logic signed [31:0]    value_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  output logic                  result_valid_o,
  output logic [31:0]           variance_o,
  output logic [ColW-1:0]       first_col_o,
  output logic [ColW-1:0]       second_col_o,
  output logic                  saturated_o,
  output logic                  out_of_range_o
);
  logic [31:0] mem [MaxRows*MaxCols];
  logic [31:0] rd_q;
  logic [AddrW-1:0] raddr;

  state_e st_q, st_d;
  logic [RcntW-1:0] rows_q;
  logic [CcntW-1:0] cols_q;
  logic [ColW-1:0] ca_q, cb_q;
  logic [RowW:0] r_q, r_d, n_q;
  logic pass2_q, pass2_d;
  logic signed [31:0] a_q, a_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [DiffW-1:0] mean_q, mean_d;
  logic [DevW-1:0] mag_q, mag_d;
  logic [SqW-1:0] sq_q;
  logic [AccW-1:0] acc_q, acc_d;
  logic [31:0] var_q, var_d;
  logic sat_q, sat_d, oor_q, oor_d, vld_q, vld_d;
  logic dv_start;
  logic [AccW-1:0] dvd;
  logic [DivW-1:0] dvs;
  logic dv_done;
  logic [AccW-1:0] quot;
  logic signed [DiffW-1:0] diff;
  logic signed [DevW-1:0] dev;
  logic [RowW:0] nn;
  logic sum_neg;
  logic [AccW-1:0] qs;

  assign cfg_ready_o = 1'b1;
  assign busy = (st_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RcntW'(256);
      cols_q <= CcntW'(64);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegRows) rows_q <= cfg_data_i[RcntW-1:0];
      else cols_q <= cfg_data_i[CcntW-1:0];
    end
  end

  always_comb begin
    if (rows_q < RcntW'(2)) nn = (RowW+1)'(2);
    else if (rows_q > RcntW'(MaxRows)) nn = (RowW+1)'(MaxRows);
    else nn = (RowW+1)'(rows_q);
  end

  assign raddr = (st_q == StRdA) ? {ca_q, r_q[RowW-1:0]} : {cb_q, r_q[RowW-1:0]};

  always_ff @(posedge clk_i) begin
    if (start && !busy && operation_i == OpLoad)
      mem[{col_index_i, row_index_i}] <= value_i;
    rd_q <= mem[raddr];
  end

  assign diff = DiffW'(a_q) - DiffW'($signed(rd_q));
  assign dev  = DevW'(diff) - DevW'(mean_q);
  assign sum_neg = sum_q[SumW-1];
  assign qs = quot;

  always_comb begin
    st_d = st_q; r_d = r_q; pass2_d = pass2_q; a_d = a_q; sum_d = sum_q;
    mean_d = mean_q; mag_d = mag_q; acc_d = acc_q; var_d = var_q;
    sat_d = sat_q; oor_d = oor_q; vld_d = 1'b0;
    dv_start = 1'b0; dvd = '0; dvs = '0;
    case (st_q)
      StIdle: begin
        if (start && operation_i == OpQuery) begin
          var_d = '0; sat_d = 1'b0; oor_d = 1'b0;
          if ((CcntW+1)'(col_index_i) >= (CcntW+1)'(cols_q) ||
              (CcntW+1)'(other_col_i) >= (CcntW+1)'(cols_q)) begin
            oor_d = 1'b1; st_d = StOut;
          end else if (col_index_i == other_col_i) begin
            var_d = 32'(1 << FracBits); st_d = StOut;
          end else begin
            r_d = '0; pass2_d = 1'b0; sum_d = '0; acc_d = '0; st_d = StRdA;
          end
        end
      end
      StRdA: st_d = StRdB;
      StRdB: begin a_d = $signed(rd_q); st_d = StAcc; end
      StAcc: begin
        if (!pass2_q) begin
          sum_d = sum_q + SumW'(diff);
          st_d = (r_q == n_q - 1'b1) ? StDiv : StRdA;
          if (r_q == n_q - 1'b1) begin
            // divide the magnitude of the complete sum; sign is restored after
            dv_start = 1'b1;
            dvd = AccW'(sum_d[SumW-1] ? -sum_d : sum_d);
            dvs = DivW'(n_q);
          end
        end else begin
          mag_d = dev[DevW-1] ? DevW'(-dev) : DevW'(dev);
          st_d = StMul;
        end
        r_d = r_q + 1'b1;
      end
      StMul: st_d = StSq;
      StSq: begin
        acc_d = acc_q + AccW'(sq_q);
        if (r_q == n_q) begin
          dv_start = 1'b1;
          dvd = acc_d;
          dvs = DivW'((n_q - 1'b1)) << FracBits;
          st_d = StDiv;
        end else st_d = StRdA;
      end
      StDiv: begin
        if (dv_done) begin
          if (!pass2_q) begin
            mean_d = sum_neg ? -DiffW'(qs) : DiffW'(qs);
            pass2_d = 1'b1; r_d = '0; st_d = StRdA;
          end else begin
            if (qs[AccW-1:32] != '0) begin var_d = '1; sat_d = 1'b1; end
            else var_d = qs[31:0];
            st_d = StOut;
          end
        end
      end
      StOut: begin vld_d = 1'b1; st_d = StIdle; end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; pass2_q <= pass2_d; a_q <= a_d; sum_q <= sum_d; mean_q <= mean_d;
    mag_q <= mag_d; sq_q <= mag_q * mag_q; acc_q <= acc_d; var_q <= var_d;
    sat_q <= sat_d; oor_q <= oor_d;
    if (start && !busy) begin
      ca_q <= col_index_i; cb_q <= other_col_i; n_q <= nn;
    end
  end

  pdv_divider u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .dividend_i(dvd), .divisor_i(dvs),
    .done_o(dv_done), .quot_o(quot)
  );

  assign result_valid_o = vld_q;
  assign variance_o = var_q;
  assign first_col_o = ca_q;
  assign second_col_o = cb_q;
  assign saturated_o = sat_q;
  assign out_of_range_o = oor_q;
endmodule
